// ===== rtl/core/gmkc_pkg.sv =====
// shared constants, types and helpers of the greedy max-k-cut partitioner
package gmkc_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int NCNT_W      = NODE_W + 1;
  localparam int MAX_EDGES   = 4096;
  localparam int EDGE_W      = $clog2(MAX_EDGES);
  localparam int ECNT_W      = EDGE_W + 1;
  localparam int ADJ_DEPTH   = 2 * MAX_EDGES;
  localparam int ADJ_W       = $clog2(ADJ_DEPTH);
  localparam int ACNT_W      = ADJ_W + 1;
  localparam int MAX_COLOURS = 16;
  localparam int COL_W       = $clog2(MAX_COLOURS);
  localparam int KCNT_W      = COL_W + 1;
  localparam int LOSS_DEPTH  = MAX_NODES * MAX_COLOURS;
  localparam int LOSS_AW     = NODE_W + COL_W;
  localparam int WT_W        = 16;
  localparam int LOSS_W      = 32;
  localparam int IDX_W       = LOSS_AW + 1;
  localparam int MODE_W      = 3;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;

  localparam int EDGE_REC_W  = 2 * NODE_W + WT_W;
  localparam int ADJ_REC_W   = NODE_W + WT_W;
  localparam int NODE_REC_W  = COL_W + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR   = 3'd0,
    MODE_PRESET  = 3'd1,
    MODE_ADD     = 3'd2,
    MODE_RUN     = 3'd3,
    MODE_READ    = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NODE_RNG  = 3'd2,
    ST_COL_RNG   = 3'd3,
    ST_NOT_RUN   = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_COLOURS = 1'b0,
    REG_NUM_NODES   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic sub;
  } alu_op_t;

  function automatic logic [LOSS_W-1:0] sext_wt(input logic [WT_W-1:0] w);
    return {{(LOSS_W-WT_W){w[WT_W-1]}}, w};
  endfunction

endpackage

// ===== rtl/core/gmkc_ram.sv =====
// generic single write port ram with registered read
module gmkc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/gmkc_alu.sv =====
// shared add, subtract and signed compare unit
module gmkc_alu (
  input  gmkc_pkg::alu_op_t               op_i,
  input  logic [gmkc_pkg::LOSS_W-1:0]     a_i,
  input  logic [gmkc_pkg::LOSS_W-1:0]     b_i,
  output logic [gmkc_pkg::LOSS_W-1:0]     res_o,
  output logic                            lt_o
);
  import gmkc_pkg::*;

  assign res_o = op_i.sub ? (a_i - b_i) : (a_i + b_i);
  assign lt_o  = $signed(a_i) < $signed(b_i);

endmodule

// ===== rtl/core/greedy_max_k_cut_partitioner.sv =====
// top level: sequencer, stores and shared unit of the greedy max-k-cut partitioner
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------------
//  in      | input     | in_valid_i / in_stall_o | mode, node_a, node_b, edge_weight,
//          |           |                         | fixed_colour
//  out     | output    | out_valid_o/out_stall_i | status, cut_weight, node_colour
//  cfg     | input     | cfg_we_i                | cfg_index_i, cfg_wdata_i
//
// modes: preassign, add edge, unknown modes and rejected reads answer from the execute
//   state, a valid read after a node store read; clear sweeps one node store entry per cycle
// run: loss table clearing sweep, count walk over stored edges, prefix walk, place walk,
//   four node walks (least-loss scan except in seed walk, then spread over adjacency
//   entries), relabel walk and cut walk; loss, degree, prefix and cut arithmetic share
//   the one add/compare unit
// reset: a clearing pass over the whole node store, no item taken meanwhile
// stalls: one item in flight; a new transfer is taken once the result slot frees
module greedy_max_k_cut_partitioner (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [gmkc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gmkc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [gmkc_pkg::MODE_W-1:0]       mode_i,
  input  logic [gmkc_pkg::NODE_W-1:0]       node_a_i,
  input  logic [gmkc_pkg::NODE_W-1:0]       node_b_i,
  input  logic signed [gmkc_pkg::WT_W-1:0]  edge_weight_i,
  input  logic [gmkc_pkg::COL_W-1:0]        fixed_colour_i,
  // results
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [gmkc_pkg::STATUS_W-1:0]     status_o,
  output logic signed [gmkc_pkg::LOSS_W-1:0] cut_weight_o,
  output logic [gmkc_pkg::COL_W-1:0]        node_colour_o
);
  import gmkc_pkg::*;

  // sequencer states, one-hot
  typedef enum logic [24:0] {
    S_IDLE     = 25'h0000001,
    S_EXEC     = 25'h0000002,
    S_RD_NODE  = 25'h0000004,
    S_CLR_NODE = 25'h0000008,
    S_CLR_LOSS = 25'h0000010,
    S_ED_RD    = 25'h0000020,
    S_ED_A     = 25'h0000040,
    S_ED_UA    = 25'h0000080,
    S_ED_UB    = 25'h0000100,
    S_PFX_RD   = 25'h0000200,
    S_PFX_WR   = 25'h0000400,
    S_NW_RD    = 25'h0000800,
    S_NW_DEC   = 25'h0001000,
    S_LL_RD    = 25'h0002000,
    S_LL_CMP   = 25'h0004000,
    S_SP_RD    = 25'h0008000,
    S_SP_LRD   = 25'h0010000,
    S_SP_WR    = 25'h0020000,
    S_RL_RD    = 25'h0040000,
    S_RL_WR    = 25'h0080000,
    S_CT_RD    = 25'h0100000,
    S_CT_A     = 25'h0200000,
    S_CT_B     = 25'h0400000,
    S_CT_CMP   = 25'h0800000,
    S_FINISH   = 25'h1000000
  } state_e;

  // node walk phases
  localparam logic [1:0] PH_SEED   = 2'd0;
  localparam logic [1:0] PH_GREEDY = 2'd1;
  localparam logic [1:0] PH_LAST   = 2'd3;

  state_e state_q, state_d;

  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [NODE_W-1:0]  a_q, a_d, b_q, b_d;
  logic [WT_W-1:0]    w_q, w_d;
  logic [COL_W-1:0]   fc_q, fc_d;

  logic [KCNT_W-1:0]  k_q, k_d;
  logic [NCNT_W-1:0]  n_q, n_d;
  logic [ECNT_W-1:0]  ecount_q, ecount_d;
  logic               run_done_q, run_done_d;
  logic [LOSS_W-1:0]  cut_q, cut_d;

  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [1:0]         phase_q, phase_d;
  logic               clr_resp_q, clr_resp_d;

  logic [NODE_W-1:0]  ea_q, ea_d, eb_q, eb_d;
  logic [WT_W-1:0]    ew_q, ew_d;
  logic [ACNT_W-1:0]  sum_q, sum_d;

  logic [COL_W-1:0]   cur_col_q, cur_col_d;
  logic [ACNT_W-1:0]  sp_start_q, sp_start_d, sp_i_q, sp_i_d, sp_end_q, sp_end_d;
  logic [COL_W-1:0]   sp_col_q, sp_col_d;
  logic               sp_sub_q, sp_sub_d, sp_second_q, sp_second_d;
  logic [COL_W-1:0]   best_q, best_d;
  logic [LOSS_W-1:0]  best_loss_q, best_loss_d;
  logic [KCNT_W-1:0]  ci_q, ci_d;
  logic [NODE_W-1:0]  nb_q, nb_d;
  logic [WT_W-1:0]    nw_q, nw_d;

  logic [MAX_COLOURS-1:0] mapped_q, mapped_d;
  logic [COL_W-1:0]       relabel_q [MAX_COLOURS];
  logic [COL_W-1:0]       relabel_d [MAX_COLOURS];
  logic [KCNT_W-1:0]      lbl_q, lbl_d;
  logic [COL_W-1:0]       col_a_q, col_a_d;

  logic                   out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]    out_status_q, out_status_d;
  logic [LOSS_W-1:0]      out_cut_q, out_cut_d;
  logic [COL_W-1:0]       out_col_q, out_col_d;

  // ram ports
  logic                   edge_we;
  logic [EDGE_W-1:0]      edge_waddr, edge_raddr;
  logic [EDGE_REC_W-1:0]  edge_wdata, edge_rdata;
  logic                   node_we;
  logic [NODE_W-1:0]      node_waddr, node_raddr;
  logic [NODE_REC_W-1:0]  node_wdata, node_rdata;
  logic                   start_we;
  logic [NODE_W-1:0]      start_waddr, start_raddr;
  logic [ACNT_W-1:0]      start_wdata, start_rdata;
  logic                   fill_we;
  logic [NODE_W-1:0]      fill_waddr, fill_raddr;
  logic [ACNT_W-1:0]      fill_wdata, fill_rdata;
  logic                   adj_we;
  logic [ADJ_W-1:0]       adj_waddr, adj_raddr;
  logic [ADJ_REC_W-1:0]   adj_wdata, adj_rdata;
  logic                   loss_we;
  logic [LOSS_AW-1:0]     loss_waddr, loss_raddr;
  logic [LOSS_W-1:0]      loss_wdata, loss_rdata;

  // shared unit
  alu_op_t            alu_op;
  logic [LOSS_W-1:0]  alu_a, alu_b, alu_res;
  logic               alu_lt;

  // response shorthand
  logic               resp;
  logic [STATUS_W-1:0] resp_status;
  logic [LOSS_W-1:0]  resp_cut;
  logic [COL_W-1:0]   resp_col;

  logic               in_xfer;
  logic               slot_free;
  logic               rd_live;
  logic               take_new;
  logic [COL_W-1:0]   best_new;
  logic [COL_W-1:0]   rl_col;
  logic [COL_W-1:0]   rl_lbl;

  gmkc_ram #(.Width(EDGE_REC_W), .Depth(MAX_EDGES)) u_edge_ram (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .raddr_i(edge_raddr), .rdata_o(edge_rdata)
  );
  gmkc_ram #(.Width(NODE_REC_W), .Depth(MAX_NODES)) u_node_ram (
    .clk_i, .we_i(node_we), .waddr_i(node_waddr), .wdata_i(node_wdata),
    .raddr_i(node_raddr), .rdata_o(node_rdata)
  );
  gmkc_ram #(.Width(ACNT_W), .Depth(MAX_NODES)) u_start_ram (
    .clk_i, .we_i(start_we), .waddr_i(start_waddr), .wdata_i(start_wdata),
    .raddr_i(start_raddr), .rdata_o(start_rdata)
  );
  gmkc_ram #(.Width(ACNT_W), .Depth(MAX_NODES)) u_fill_ram (
    .clk_i, .we_i(fill_we), .waddr_i(fill_waddr), .wdata_i(fill_wdata),
    .raddr_i(fill_raddr), .rdata_o(fill_rdata)
  );
  gmkc_ram #(.Width(ADJ_REC_W), .Depth(ADJ_DEPTH)) u_adj_ram (
    .clk_i, .we_i(adj_we), .waddr_i(adj_waddr), .wdata_i(adj_wdata),
    .raddr_i(adj_raddr), .rdata_o(adj_rdata)
  );
  gmkc_ram #(.Width(LOSS_W), .Depth(LOSS_DEPTH)) u_loss_ram (
    .clk_i, .we_i(loss_we), .waddr_i(loss_waddr), .wdata_i(loss_wdata),
    .raddr_i(loss_raddr), .rdata_o(loss_rdata)
  );

  gmkc_alu u_alu (
    .op_i(alu_op), .a_i(alu_a), .b_i(alu_b), .res_o(alu_res), .lt_o(alu_lt)
  );

  // one item in flight; result slot frees at the same edge it is taken
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && slot_free);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // edge read back from the store is live when both ends are in use
  assign rd_live = ({1'b0, edge_rdata[EDGE_REC_W-1 -: NODE_W]} < n_q) &&
                   ({1'b0, edge_rdata[WT_W +: NODE_W]} < n_q);

  // least-loss scan: strict less keeps the lowest colour on ties
  assign take_new = (ci_q == '0) || alu_lt;
  assign best_new = take_new ? ci_q[COL_W-1:0] : best_q;

  // relabel by first use
  assign rl_col = node_rdata[COL_W-1:0];
  assign rl_lbl = mapped_q[rl_col] ? relabel_q[rl_col] : lbl_q[COL_W-1:0];

  always_comb begin
    // hold by default
    state_d      = state_q;
    mode_d       = mode_q;
    a_d          = a_q;
    b_d          = b_q;
    w_d          = w_q;
    fc_d         = fc_q;
    k_d          = k_q;
    n_d          = n_q;
    ecount_d     = ecount_q;
    run_done_d   = run_done_q;
    cut_d        = cut_q;
    idx_d        = idx_q;
    phase_d      = phase_q;
    clr_resp_d   = clr_resp_q;
    ea_d         = ea_q;
    eb_d         = eb_q;
    ew_d         = ew_q;
    sum_d        = sum_q;
    cur_col_d    = cur_col_q;
    sp_start_d   = sp_start_q;
    sp_i_d       = sp_i_q;
    sp_end_d     = sp_end_q;
    sp_col_d     = sp_col_q;
    sp_sub_d     = sp_sub_q;
    sp_second_d  = sp_second_q;
    best_d       = best_q;
    best_loss_d  = best_loss_q;
    ci_d         = ci_q;
    nb_d         = nb_q;
    nw_d         = nw_q;
    mapped_d     = mapped_q;
    relabel_d    = relabel_q;
    lbl_d        = lbl_q;
    col_a_d      = col_a_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_cut_d    = out_cut_q;
    out_col_d    = out_col_q;

    resp        = 1'b0;
    resp_status = ST_OK;
    resp_cut    = '0;
    resp_col    = '0;

    edge_we     = 1'b0;
    edge_waddr  = ecount_q[EDGE_W-1:0];
    edge_wdata  = {a_q, b_q, w_q};
    edge_raddr  = idx_q[EDGE_W-1:0];
    node_we     = 1'b0;
    node_waddr  = idx_q[NODE_W-1:0];
    node_wdata  = '0;
    node_raddr  = idx_q[NODE_W-1:0];
    start_we    = 1'b0;
    start_waddr = idx_q[NODE_W-1:0];
    start_wdata = sum_q;
    start_raddr = idx_q[NODE_W-1:0];
    fill_we     = 1'b0;
    fill_waddr  = idx_q[NODE_W-1:0];
    fill_wdata  = '0;
    fill_raddr  = idx_q[NODE_W-1:0];
    adj_we      = 1'b0;
    adj_waddr   = fill_rdata[ADJ_W-1:0];
    adj_wdata   = '0;
    adj_raddr   = sp_i_q[ADJ_W-1:0];
    loss_we     = 1'b0;
    loss_waddr  = {nb_q, sp_col_q};
    loss_wdata  = '0;
    loss_raddr  = {idx_q[NODE_W-1:0], ci_q[COL_W-1:0]};

    alu_op.sub  = 1'b0;
    alu_a       = '0;
    alu_b       = '0;

    // configuration registers, low field bits saturated into their ranges
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_NUM_COLOURS: begin
          if (cfg_wdata_i[KCNT_W-1:0] < KCNT_W'(2)) begin
            k_d = KCNT_W'(2);
          end else if (cfg_wdata_i[KCNT_W-1:0] > KCNT_W'(MAX_COLOURS)) begin
            k_d = KCNT_W'(MAX_COLOURS);
          end else begin
            k_d = cfg_wdata_i[KCNT_W-1:0];
          end
        end
        REG_NUM_NODES: begin
          if (cfg_wdata_i[NCNT_W-1:0] == '0) begin
            n_d = NCNT_W'(1);
          end else if (cfg_wdata_i[NCNT_W-1:0] > NCNT_W'(MAX_NODES)) begin
            n_d = NCNT_W'(MAX_NODES);
          end else begin
            n_d = cfg_wdata_i[NCNT_W-1:0];
          end
        end
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          mode_d  = mode_i;
          a_d     = node_a_i;
          b_d     = node_b_i;
          w_d     = edge_weight_i;
          fc_d    = fixed_colour_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        priority if (mode_q == MODE_CLEAR) begin
          ecount_d   = '0;
          run_done_d = 1'b0;
          cut_d      = '0;
          idx_d      = '0;
          clr_resp_d = 1'b1;
          state_d    = S_CLR_NODE;
        end else if (mode_q == MODE_PRESET) begin
          resp = 1'b1;
          if ({1'b0, a_q} >= n_q) begin
            resp_status = ST_NODE_RNG;
          end else if ({1'b0, fc_q} >= k_q) begin
            resp_status = ST_COL_RNG;
          end else begin
            node_we    = 1'b1;
            node_waddr = a_q;
            node_wdata = {1'b1, fc_q};
            run_done_d = 1'b0;
          end
        end else if (mode_q == MODE_ADD) begin
          resp = 1'b1;
          if (({1'b0, a_q} >= n_q) || ({1'b0, b_q} >= n_q)) begin
            resp_status = ST_NODE_RNG;
          end else if (ecount_q >= ECNT_W'(MAX_EDGES)) begin
            resp_status = ST_FULL;
          end else begin
            edge_we    = 1'b1;
            ecount_d   = ecount_q + ECNT_W'(1);
            run_done_d = 1'b0;
          end
        end else if (mode_q == MODE_RUN) begin
          idx_d   = '0;
          state_d = S_CLR_LOSS;
        end else if (mode_q == MODE_READ) begin
          if (!run_done_q) begin
            resp        = 1'b1;
            resp_status = ST_NOT_RUN;
          end else if ({1'b0, a_q} >= n_q) begin
            resp        = 1'b1;
            resp_status = ST_NODE_RNG;
            resp_cut    = cut_q;
          end else begin
            node_raddr = a_q;
            state_d    = S_RD_NODE;
          end
        end else begin
          // unknown mode: plain zero result
          resp = 1'b1;
        end
      end

      S_RD_NODE: begin
        resp     = 1'b1;
        resp_cut = cut_q;
        resp_col = node_rdata[COL_W-1:0];
      end

      // node store sweep after reset and on clear
      S_CLR_NODE: begin
        node_we    = 1'b1;
        node_wdata = '0;
        if (idx_q[NODE_W-1:0] == NODE_W'(MAX_NODES - 1)) begin
          idx_d = '0;
          if (clr_resp_q) begin
            resp = 1'b1;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      // loss table sweep; fill counters cleared along the way
      S_CLR_LOSS: begin
        loss_we    = 1'b1;
        loss_waddr = idx_q[LOSS_AW-1:0];
        loss_wdata = '0;
        if (idx_q[IDX_W-1:NODE_W] == '0) begin
          fill_we    = 1'b1;
          fill_wdata = '0;
        end
        if (idx_q[LOSS_AW-1:0] == LOSS_AW'(LOSS_DEPTH - 1)) begin
          idx_d   = '0;
          phase_d = PH_SEED;
          state_d = S_ED_RD;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      // edge walk: phase 0 counts degrees, phase 1 places adjacency entries
      S_ED_RD: begin
        if (idx_q[ECNT_W-1:0] == ecount_q) begin
          idx_d = '0;
          if (phase_q == PH_SEED) begin
            sum_d   = '0;
            state_d = S_PFX_RD;
          end else begin
            phase_d = PH_SEED;
            state_d = S_NW_RD;
          end
        end else begin
          state_d = S_ED_A;
        end
      end

      S_ED_A: begin
        ea_d = edge_rdata[EDGE_REC_W-1 -: NODE_W];
        eb_d = edge_rdata[WT_W +: NODE_W];
        ew_d = edge_rdata[WT_W-1:0];
        if (rd_live) begin
          fill_raddr = edge_rdata[EDGE_REC_W-1 -: NODE_W];
          state_d    = S_ED_UA;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_ED_RD;
        end
      end

      S_ED_UA: begin
        alu_a      = LOSS_W'(fill_rdata);
        alu_b      = LOSS_W'(1);
        fill_we    = 1'b1;
        fill_waddr = ea_q;
        fill_wdata = alu_res[ACNT_W-1:0];
        if (phase_q != PH_SEED) begin
          adj_we    = 1'b1;
          adj_wdata = {eb_q, ew_q};
        end
        if (ea_q != eb_q) begin
          fill_raddr = eb_q;
          state_d    = S_ED_UB;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_ED_RD;
        end
      end

      S_ED_UB: begin
        alu_a      = LOSS_W'(fill_rdata);
        alu_b      = LOSS_W'(1);
        fill_we    = 1'b1;
        fill_waddr = eb_q;
        fill_wdata = alu_res[ACNT_W-1:0];
        if (phase_q != PH_SEED) begin
          adj_we    = 1'b1;
          adj_wdata = {ea_q, ew_q};
        end
        idx_d   = idx_q + IDX_W'(1);
        state_d = S_ED_RD;
      end

      // running sum of degrees gives each node its adjacency start
      S_PFX_RD: begin
        if (idx_q[NCNT_W-1:0] == n_q) begin
          idx_d   = '0;
          phase_d = PH_GREEDY;
          state_d = S_ED_RD;
        end else begin
          state_d = S_PFX_WR;
        end
      end

      S_PFX_WR: begin
        alu_a      = LOSS_W'(sum_q);
        alu_b      = LOSS_W'(fill_rdata);
        start_we   = 1'b1;
        fill_we    = 1'b1;
        fill_wdata = sum_q;
        sum_d      = alu_res[ACNT_W-1:0];
        idx_d      = idx_q + IDX_W'(1);
        state_d    = S_PFX_RD;
      end

      // node walks: seed, greedy, two refinement passes
      S_NW_RD: begin
        if (idx_q[NCNT_W-1:0] == n_q) begin
          idx_d = '0;
          if (phase_q == PH_LAST) begin
            mapped_d = '0;
            lbl_d    = '0;
            state_d  = S_RL_RD;
          end else begin
            phase_d = phase_q + 2'd1;
          end
        end else begin
          state_d = S_NW_DEC;
        end
      end

      S_NW_DEC: begin
        cur_col_d   = node_rdata[COL_W-1:0];
        sp_start_d  = start_rdata;
        sp_i_d      = start_rdata;
        sp_end_d    = fill_rdata;
        ci_d        = '0;
        sp_second_d = 1'b0;
        sp_sub_d    = 1'b0;
        sp_col_d    = node_rdata[COL_W-1:0];
        priority if (phase_q == PH_SEED) begin
          if (node_rdata[COL_W]) begin
            state_d = S_SP_RD;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_NW_RD;
          end
        end else if (phase_q == PH_GREEDY) begin
          if (node_rdata[COL_W]) begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_NW_RD;
          end else begin
            state_d = S_LL_RD;
          end
        end else begin
          state_d = S_LL_RD;
        end
      end

      S_LL_RD: begin
        state_d = S_LL_CMP;
      end

      S_LL_CMP: begin
        alu_a       = loss_rdata;
        alu_b       = best_loss_q;
        if (take_new) begin
          best_loss_d = loss_rdata;
        end
        best_d = best_new;
        if (ci_q == k_q - KCNT_W'(1)) begin
          sp_col_d = best_new;
          sp_sub_d = 1'b0;
          if (phase_q == PH_GREEDY) begin
            node_we    = 1'b1;
            node_wdata = {1'b1, best_new};
            state_d    = S_SP_RD;
          end else if (best_new != cur_col_q) begin
            node_we     = 1'b1;
            node_wdata  = {1'b1, best_new};
            sp_second_d = 1'b1;
            state_d     = S_SP_RD;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_NW_RD;
          end
        end else begin
          ci_d    = ci_q + KCNT_W'(1);
          state_d = S_LL_RD;
        end
      end

      // spread: add or take off this node's weights in its neighbours' losses
      S_SP_RD: begin
        if (sp_i_q == sp_end_q) begin
          if (sp_second_q) begin
            sp_second_d = 1'b0;
            sp_col_d    = cur_col_q;
            sp_sub_d    = 1'b1;
            sp_i_d      = sp_start_q;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_NW_RD;
          end
        end else begin
          state_d = S_SP_LRD;
        end
      end

      S_SP_LRD: begin
        nb_d       = adj_rdata[ADJ_REC_W-1 -: NODE_W];
        nw_d       = adj_rdata[WT_W-1:0];
        loss_raddr = {adj_rdata[ADJ_REC_W-1 -: NODE_W], sp_col_q};
        state_d    = S_SP_WR;
      end

      S_SP_WR: begin
        alu_op.sub = sp_sub_q;
        alu_a      = loss_rdata;
        alu_b      = sext_wt(nw_q);
        loss_we    = 1'b1;
        loss_wdata = alu_res;
        sp_i_d     = sp_i_q + ACNT_W'(1);
        state_d    = S_SP_RD;
      end

      S_RL_RD: begin
        if (idx_q[NCNT_W-1:0] == n_q) begin
          idx_d   = '0;
          cut_d   = '0;
          state_d = S_CT_RD;
        end else begin
          state_d = S_RL_WR;
        end
      end

      S_RL_WR: begin
        if (!mapped_q[rl_col]) begin
          mapped_d[rl_col]  = 1'b1;
          relabel_d[rl_col] = lbl_q[COL_W-1:0];
          lbl_d             = lbl_q + KCNT_W'(1);
        end
        node_we    = 1'b1;
        node_wdata = {1'b1, rl_lbl};
        idx_d      = idx_q + IDX_W'(1);
        state_d    = S_RL_RD;
      end

      // cut sum over live edges
      S_CT_RD: begin
        if (idx_q[ECNT_W-1:0] == ecount_q) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_CT_A;
        end
      end

      S_CT_A: begin
        ea_d = edge_rdata[EDGE_REC_W-1 -: NODE_W];
        eb_d = edge_rdata[WT_W +: NODE_W];
        ew_d = edge_rdata[WT_W-1:0];
        if (rd_live) begin
          node_raddr = edge_rdata[EDGE_REC_W-1 -: NODE_W];
          state_d    = S_CT_B;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_CT_RD;
        end
      end

      S_CT_B: begin
        col_a_d    = node_rdata[COL_W-1:0];
        node_raddr = eb_q;
        state_d    = S_CT_CMP;
      end

      S_CT_CMP: begin
        alu_a = cut_q;
        alu_b = sext_wt(ew_q);
        if (node_rdata[COL_W-1:0] != col_a_q) begin
          cut_d = alu_res;
        end
        idx_d   = idx_q + IDX_W'(1);
        state_d = S_CT_RD;
      end

      S_FINISH: begin
        run_done_d = 1'b1;
        resp       = 1'b1;
        resp_cut   = cut_q;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (resp) begin
      out_valid_d  = 1'b1;
      out_status_d = resp_status;
      out_cut_d    = resp_cut;
      out_col_d    = resp_col;
      state_d      = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR_NODE;
      k_q          <= KCNT_W'(2);
      n_q          <= NCNT_W'(MAX_NODES);
      ecount_q     <= '0;
      run_done_q   <= 1'b0;
      cut_q        <= '0;
      idx_q        <= '0;
      phase_q      <= PH_SEED;
      clr_resp_q   <= 1'b0;
      sp_second_q  <= 1'b0;
      mapped_q     <= '0;
      lbl_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      k_q          <= k_d;
      n_q          <= n_d;
      ecount_q     <= ecount_d;
      run_done_q   <= run_done_d;
      cut_q        <= cut_d;
      idx_q        <= idx_d;
      phase_q      <= phase_d;
      clr_resp_q   <= clr_resp_d;
      sp_second_q  <= sp_second_d;
      mapped_q     <= mapped_d;
      lbl_q        <= lbl_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    a_q          <= a_d;
    b_q          <= b_d;
    w_q          <= w_d;
    fc_q         <= fc_d;
    ea_q         <= ea_d;
    eb_q         <= eb_d;
    ew_q         <= ew_d;
    sum_q        <= sum_d;
    cur_col_q    <= cur_col_d;
    sp_start_q   <= sp_start_d;
    sp_i_q       <= sp_i_d;
    sp_end_q     <= sp_end_d;
    sp_col_q     <= sp_col_d;
    sp_sub_q     <= sp_sub_d;
    best_q       <= best_d;
    best_loss_q  <= best_loss_d;
    ci_q         <= ci_d;
    nb_q         <= nb_d;
    nw_q         <= nw_d;
    relabel_q    <= relabel_d;
    col_a_q      <= col_a_d;
    out_status_q <= out_status_d;
    out_cut_q    <= out_cut_d;
    out_col_q    <= out_col_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign cut_weight_o  = out_cut_q;
  assign node_colour_o = out_col_q;

  // a spread step never runs past the node's adjacency end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SP_LRD) |-> (sp_i_q < sp_end_q))
    else $error("spread index beyond adjacency end");

  // least-loss scan stays within the colours in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LL_CMP) |-> (ci_q < k_q))
    else $error("colour scan beyond num_colours");

  // a finished run always leaves run_done set with its result pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH) |=> (run_done_q && out_valid_q))
    else $error("run finished without result");

  // relabelling never hands out more labels than there are colours
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lbl_q <= KCNT_W'(MAX_COLOURS))
    else $error("relabel count overflow");

endmodule
